// File: rtl/core/sbc_pkg.sv
// sbc_pkg: shared constants for the swept box collision pipeline.
// No dependencies.
package sbc_pkg;

  localparam int DT_W      = 16;
  localparam int TL_W      = 16;
  localparam int PRE_SHIFT = 14;
  localparam logic [DT_W-1:0] FT_RESET = 16'd1092;

endpackage

// File: rtl/core/swept_box_collision.sv
// swept_box_collision: top level; front stages, four pipelined dividers,
// back stages, frame time register. Uses sbc_pkg, sbc_front, sbc_div, sbc_back.
// Throughput: one item per cycle while the pipeline advances; the divider array
// retires one quotient bit per stage.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears all valid bits and loads frame_time with 1092; no clearing pass.
module swept_box_collision import sbc_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [DT_W-1:0]                   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     tgt_x,
  input  logic signed [COORD_WIDTH-1:0]     tgt_y,
  input  logic [COORD_WIDTH-3:0]            tgt_w,
  input  logic [COORD_WIDTH-3:0]            tgt_h,
  input  logic signed [COORD_WIDTH-1:0]     tgt_vx,
  input  logic signed [COORD_WIDTH-1:0]     tgt_vy,
  input  logic signed [COORD_WIDTH-1:0]     oth_x,
  input  logic signed [COORD_WIDTH-1:0]     oth_y,
  input  logic [COORD_WIDTH-3:0]            oth_w,
  input  logic [COORD_WIDTH-3:0]            oth_h,
  input  logic signed [COORD_WIDTH-1:0]     oth_vx,
  input  logic signed [COORD_WIDTH-1:0]     oth_vy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic                              hit_axis,
  output logic signed [COORD_WIDTH-1:0]     push_x,
  output logic signed [COORD_WIDTH-1:0]     push_y,
  output logic [RATIO_FRAC_BITS:0]          entry_ratio,
  output logic [TL_W-1:0]                   time_left,
  output logic signed [COORD_WIDTH-1:0]     contact_x,
  output logic signed [COORD_WIDTH-1:0]     contact_y,
  output logic signed [COORD_WIDTH:0]       gap_x,
  output logic signed [COORD_WIDTH:0]       gap_y
);
  localparam int P       = COORD_WIDTH;
  localparam int R       = RATIO_FRAC_BITS;
  localparam int G_W     = P + 2;
  localparam int UD_W    = P + DT_W;
  localparam int Q_W     = R + 5;
  localparam int DIV_LAT = R + 4;
  localparam int NST     = 2 + DIV_LAT + 4;
  localparam int SB_W    = 2 * G_W + 2 * UD_W + 4 + 4 * P;

  logic [DT_W-1:0] frame_time;
  logic            en;
  logic [NST-1:0]  vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= FT_RESET;
    end else if (cfg_we) begin
      frame_time <= cfg_data;
    end
  end

  assign en        = !vld[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  logic signed [G_W-1:0] dxe, dxx, dye, dyx;
  logic [UD_W-1:0]       udx, udy;
  logic                  rvx_neg, rvy_neg, unbx, unby;
  logic signed [P-1:0]   tx, ty, tvx, tvy;

  sbc_front #(.COORD_WIDTH(P)) u_front (
    .clk, .en, .dt(frame_time),
    .tgt_x, .tgt_y, .tgt_w, .tgt_h, .tgt_vx, .tgt_vy,
    .oth_x, .oth_y, .oth_w, .oth_h, .oth_vx, .oth_vy,
    .dxe, .dxx, .dye, .dyx, .udx, .udy, .rvx_neg, .rvy_neg, .unbx, .unby,
    .tx, .ty, .tvx, .tvy
  );

  logic signed [Q_W-1:0] qxe, qxx, qye, qyx;

  sbc_div #(.NUM_W(G_W), .DEN_W(UD_W), .RATIO_FRAC_BITS(R)) u_div_xe (
    .clk, .en, .num(dxe), .den_neg(rvx_neg), .den(udx), .ratio(qxe));
  sbc_div #(.NUM_W(G_W), .DEN_W(UD_W), .RATIO_FRAC_BITS(R)) u_div_xx (
    .clk, .en, .num(dxx), .den_neg(rvx_neg), .den(udx), .ratio(qxx));
  sbc_div #(.NUM_W(G_W), .DEN_W(UD_W), .RATIO_FRAC_BITS(R)) u_div_ye (
    .clk, .en, .num(dye), .den_neg(rvy_neg), .den(udy), .ratio(qye));
  sbc_div #(.NUM_W(G_W), .DEN_W(UD_W), .RATIO_FRAC_BITS(R)) u_div_yx (
    .clk, .en, .num(dyx), .den_neg(rvy_neg), .den(udy), .ratio(qyx));

  // side data delayed to line up with the divider results
  logic [SB_W-1:0] sb_in, sb_out;
  logic [SB_W-1:0] sb_pipe [0:DIV_LAT-1];

  assign sb_in  = {dxe, dye, udx, udy, rvx_neg, rvy_neg, unbx, unby, tx, ty, tvx, tvy};
  assign sb_out = sb_pipe[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_pipe[0] <= sb_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_pipe[i] <= sb_pipe[i-1];
      end
    end
  end

  logic signed [G_W-1:0] d_dxe, d_dye;
  logic [UD_W-1:0]       d_udx, d_udy;
  logic                  d_nx, d_ny, d_ux, d_uy;
  logic signed [P-1:0]   d_tx, d_ty, d_tvx, d_tvy;

  assign {d_dxe, d_dye, d_udx, d_udy, d_nx, d_ny, d_ux, d_uy,
          d_tx, d_ty, d_tvx, d_tvy} = sb_out;

  sbc_back #(.COORD_WIDTH(P), .RATIO_FRAC_BITS(R)) u_back (
    .clk, .en, .dt(frame_time),
    .qxe, .qxx, .qye, .qyx,
    .dxe(d_dxe), .dye(d_dye), .udx(d_udx), .udy(d_udy),
    .rvx_neg(d_nx), .rvy_neg(d_ny), .unbx(d_ux), .unby(d_uy),
    .tx(d_tx), .ty(d_ty), .tvx(d_tvx), .tvy(d_tvy),
    .hit, .hit_axis, .push_x, .push_y, .entry_ratio, .time_left,
    .contact_x, .contact_y, .gap_x, .gap_y
  );

endmodule

// File: rtl/core/sbc_front.sv
// sbc_front: two register stages; center/size sums, relative velocity,
// edge gaps, entry/exit selection and divisor magnitude. Uses sbc_pkg.
module sbc_front import sbc_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [DT_W-1:0]                dt,
  input  logic signed [COORD_WIDTH-1:0]  tgt_x,
  input  logic signed [COORD_WIDTH-1:0]  tgt_y,
  input  logic [COORD_WIDTH-3:0]         tgt_w,
  input  logic [COORD_WIDTH-3:0]         tgt_h,
  input  logic signed [COORD_WIDTH-1:0]  tgt_vx,
  input  logic signed [COORD_WIDTH-1:0]  tgt_vy,
  input  logic signed [COORD_WIDTH-1:0]  oth_x,
  input  logic signed [COORD_WIDTH-1:0]  oth_y,
  input  logic [COORD_WIDTH-3:0]         oth_w,
  input  logic [COORD_WIDTH-3:0]         oth_h,
  input  logic signed [COORD_WIDTH-1:0]  oth_vx,
  input  logic signed [COORD_WIDTH-1:0]  oth_vy,
  output logic signed [COORD_WIDTH+1:0]  dxe,
  output logic signed [COORD_WIDTH+1:0]  dxx,
  output logic signed [COORD_WIDTH+1:0]  dye,
  output logic signed [COORD_WIDTH+1:0]  dyx,
  output logic [COORD_WIDTH+DT_W-1:0]    udx,
  output logic [COORD_WIDTH+DT_W-1:0]    udy,
  output logic                           rvx_neg,
  output logic                           rvy_neg,
  output logic                           unbx,
  output logic                           unby,
  output logic signed [COORD_WIDTH-1:0]  tx,
  output logic signed [COORD_WIDTH-1:0]  ty,
  output logic signed [COORD_WIDTH-1:0]  tvx,
  output logic signed [COORD_WIDTH-1:0]  tvy
);
  localparam int P    = COORD_WIDTH;
  localparam int T_W  = P + 3;
  localparam int UD_W = P + DT_W;

  logic signed [P:0]   cx, cy, rvx, rvy;
  logic [P-2:0]        sx, sy;
  logic signed [P-1:0] tx1, ty1, tvx1, tvy1;

  always_ff @(posedge clk) begin
    if (en) begin
      cx   <= $signed({oth_x[P-1], oth_x}) - $signed({tgt_x[P-1], tgt_x});
      cy   <= $signed({oth_y[P-1], oth_y}) - $signed({tgt_y[P-1], tgt_y});
      rvx  <= $signed({tgt_vx[P-1], tgt_vx}) - $signed({oth_vx[P-1], oth_vx});
      rvy  <= $signed({tgt_vy[P-1], tgt_vy}) - $signed({oth_vy[P-1], oth_vy});
      sx   <= {1'b0, tgt_w} + {1'b0, oth_w};
      sy   <= {1'b0, tgt_h} + {1'b0, oth_h};
      tx1  <= tgt_x;
      ty1  <= tgt_y;
      tvx1 <= tgt_vx;
      tvy1 <= tgt_vy;
    end
  end

  logic signed [T_W-1:0] twox, twoy, sxe, sye, xlo_t, xhi_t, ylo_t, yhi_t;
  logic [P:0]            magx, magy;
  logic [UD_W:0]         udx_full, udy_full;
  logic                  rvx_pos, rvy_pos;

  always_comb begin
    twox  = {cx[P], cx, 1'b0};
    twoy  = {cy[P], cy, 1'b0};
    sxe   = {4'b0, sx};
    sye   = {4'b0, sy};
    xlo_t = twox - sxe;
    xhi_t = twox + sxe;
    ylo_t = twoy - sye;
    yhi_t = twoy + sye;
    rvx_pos = !rvx[P] && (rvx != '0);
    rvy_pos = !rvy[P] && (rvy != '0);
    magx = rvx[P] ? (~rvx + 1'b1) : rvx;
    magy = rvy[P] ? (~rvy + 1'b1) : rvy;
    udx_full = magx * dt;
    udy_full = magy * dt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxe     <= rvx_pos ? xlo_t[T_W-1:1] : xhi_t[T_W-1:1];
      dxx     <= rvx_pos ? xhi_t[T_W-1:1] : xlo_t[T_W-1:1];
      dye     <= rvy_pos ? ylo_t[T_W-1:1] : yhi_t[T_W-1:1];
      dyx     <= rvy_pos ? yhi_t[T_W-1:1] : ylo_t[T_W-1:1];
      udx     <= udx_full[UD_W-1:0];
      udy     <= udy_full[UD_W-1:0];
      rvx_neg <= rvx[P];
      rvy_neg <= rvy[P];
      unbx    <= (tvx1 == '0) || (rvx == '0) || (dt == '0);
      unby    <= (tvy1 == '0) || (rvy == '0) || (dt == '0);
      tx      <= tx1;
      ty      <= ty1;
      tvx     <= tvx1;
      tvy     <= tvy1;
    end
  end

endmodule

// File: rtl/core/sbc_div.sv
// sbc_div: pipelined restoring divider, one quotient bit per stage, giving
// floor(num * 2^(16+R) / den) clamped to +/-4.0. Uses sbc_pkg.
module sbc_div import sbc_pkg::*; #(
  parameter int NUM_W           = 26,
  parameter int DEN_W           = 40,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [NUM_W-1:0]          num,
  input  logic                             den_neg,
  input  logic [DEN_W-1:0]                 den,
  output logic signed [RATIO_FRAC_BITS+4:0] ratio
);
  localparam int R     = RATIO_FRAC_BITS;
  localparam int STEPS = R + 2;
  localparam int Q_W   = R + 5;
  localparam int SH_W  = NUM_W + PRE_SHIFT;
  localparam int CMP_W = (SH_W > DEN_W ? SH_W : DEN_W) + 1;
  localparam logic signed [Q_W-1:0] LIM = Q_W'(4) <<< R;

  logic [NUM_W-1:0] un;
  logic [CMP_W-1:0] shn, dn;

  always_comb begin
    un  = num[NUM_W-1] ? (~num + 1'b1) : num;
    shn = CMP_W'({un, {PRE_SHIFT{1'b0}}});
    dn  = CMP_W'(den);
  end

  logic [DEN_W-1:0] rem [0:STEPS];
  logic [DEN_W-1:0] dv  [0:STEPS];
  logic [STEPS-1:0] q   [0:STEPS];
  logic             ng  [0:STEPS];
  logic             st  [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= shn[DEN_W-1:0];
      dv[0]  <= den;
      q[0]   <= '0;
      ng[0]  <= num[NUM_W-1] ^ den_neg;
      st[0]  <= (un != '0) && (shn >= dn);
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [DEN_W:0] r2;
    logic           ge;
    always_comb begin
      r2 = {rem[k-1], 1'b0};
      ge = r2 >= {1'b0, dv[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DEN_W'(r2 - {1'b0, dv[k-1]}) : r2[DEN_W-1:0];
        dv[k]  <= dv[k-1];
        q[k]   <= {q[k-1][STEPS-2:0], ge};
        ng[k]  <= ng[k-1];
        st[k]  <= st[k-1];
      end
    end
  end

  logic signed [Q_W-1:0] qs;
  always_comb begin
    qs = $signed(Q_W'(q[STEPS]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st[STEPS]) begin
        ratio <= ng[STEPS] ? -LIM : LIM;
      end else if (ng[STEPS]) begin
        ratio <= -qs - ((rem[STEPS] != '0) ? Q_W'(1) : Q_W'(0));
      end else begin
        ratio <= qs;
      end
    end
  end

endmodule

// File: rtl/core/sbc_back.sv
// sbc_back: four register stages; hit decision, push, time left and
// contact point with split multiplies, saturation. Uses sbc_pkg.
module sbc_back import sbc_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [DT_W-1:0]                    dt,
  input  logic signed [RATIO_FRAC_BITS+4:0]  qxe,
  input  logic signed [RATIO_FRAC_BITS+4:0]  qxx,
  input  logic signed [RATIO_FRAC_BITS+4:0]  qye,
  input  logic signed [RATIO_FRAC_BITS+4:0]  qyx,
  input  logic signed [COORD_WIDTH+1:0]      dxe,
  input  logic signed [COORD_WIDTH+1:0]      dye,
  input  logic [COORD_WIDTH+DT_W-1:0]        udx,
  input  logic [COORD_WIDTH+DT_W-1:0]        udy,
  input  logic                               rvx_neg,
  input  logic                               rvy_neg,
  input  logic                               unbx,
  input  logic                               unby,
  input  logic signed [COORD_WIDTH-1:0]      tx,
  input  logic signed [COORD_WIDTH-1:0]      ty,
  input  logic signed [COORD_WIDTH-1:0]      tvx,
  input  logic signed [COORD_WIDTH-1:0]      tvy,
  output logic                               hit,
  output logic                               hit_axis,
  output logic signed [COORD_WIDTH-1:0]      push_x,
  output logic signed [COORD_WIDTH-1:0]      push_y,
  output logic [RATIO_FRAC_BITS:0]           entry_ratio,
  output logic [TL_W-1:0]                    time_left,
  output logic signed [COORD_WIDTH-1:0]      contact_x,
  output logic signed [COORD_WIDTH-1:0]      contact_y,
  output logic signed [COORD_WIDTH:0]        gap_x,
  output logic signed [COORD_WIDTH:0]        gap_y
);
  localparam int P     = COORD_WIDTH;
  localparam int R     = RATIO_FRAC_BITS;
  localparam int Q_W   = R + 5;
  localparam int G_W   = P + 2;
  localparam int UD_W  = P + DT_W;
  localparam int H     = UD_W / 2;
  localparam int SUM_W = UD_W + R + 1;
  localparam int TP_W  = DT_W + R + 1;
  localparam logic signed [Q_W-1:0] ONE = Q_W'(1) <<< R;
  localparam logic signed [Q_W-1:0] INF = Q_W'(8) <<< R;

  // stage 1: decision
  logic signed [Q_W-1:0] rxe, rxx, rye, ryx, re_c, rx_c;
  logic                  miss_c, xwin;
  logic signed [G_W-1:0] pg;
  logic signed [P-1:0]   pv;
  logic signed [P:0]     pvx, pav, pval;
  logic signed [P-1:0]   psat;
  logic signed [P:0]     gxs, gys;

  always_comb begin
    rxe = unbx ? -INF : qxe;
    rxx = unbx ?  INF : qxx;
    rye = unby ? -INF : qye;
    ryx = unby ?  INF : qyx;
    xwin = rxe > rye;
    re_c = xwin ? rxe : rye;
    rx_c = (rxx < ryx) ? rxx : ryx;
    miss_c = (re_c > rx_c) || (rxe < 0 && rye < 0) || (rxe > ONE) || (rye > ONE);
    pg  = xwin ? dxe : dye;
    pv  = xwin ? tvx : tvy;
    pvx = {pv[P-1], pv};
    pav = pv[P-1] ? -pvx : pvx;
    if (pg == '0) begin
      pval = -pvx;
    end else if (pg < 0) begin
      pval = pav;
    end else begin
      pval = -pav;
    end
    if (pval[P] != pval[P-1]) begin
      psat = {pval[P], {(P-1){~pval[P]}}};
    end else begin
      psat = pval[P-1:0];
    end
    gxs = (dxe[G_W-1] != dxe[G_W-2]) ? {dxe[G_W-1], {P{~dxe[G_W-1]}}} : dxe[P:0];
    gys = (dye[G_W-1] != dye[G_W-2]) ? {dye[G_W-1], {P{~dye[G_W-1]}}} : dye[P:0];
  end

  logic                  hit1, axis1, nx1, ny1;
  logic signed [Q_W-1:0] re1;
  logic signed [P-1:0]   push1, tx1, ty1;
  logic signed [P:0]     gx1, gy1;
  logic [UD_W-1:0]       udx1, udy1;

  always_ff @(posedge clk) begin
    if (en) begin
      hit1  <= !miss_c;
      axis1 <= !xwin;
      re1   <= re_c;
      push1 <= psat;
      gx1   <= gxs;
      gy1   <= gys;
      udx1  <= udx;
      udy1  <= udy;
      nx1   <= rvx_neg;
      ny1   <= rvy_neg;
      tx1   <= tx;
      ty1   <= ty;
    end
  end

  // stage 2: products
  logic [R:0]             rmag, rrem;
  logic                   hit2, axis2, nx2, ny2;
  logic [R:0]             re2;
  logic signed [P-1:0]    push2, tx2, ty2;
  logic signed [P:0]      gx2, gy2;
  logic [TP_W-1:0]        tp2;
  logic [UD_W-H+R:0]      pax2, pay2;
  logic [H+R:0]           pbx2, pby2;

  always_comb begin
    rmag = re1[R:0];
    rrem = ONE[R:0] - rmag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit2  <= hit1;
      axis2 <= axis1;
      nx2   <= nx1;
      ny2   <= ny1;
      re2   <= rmag;
      push2 <= push1;
      tx2   <= tx1;
      ty2   <= ty1;
      gx2   <= gx1;
      gy2   <= gy1;
      tp2   <= dt * rrem;
      pax2  <= udx1[UD_W-1:H] * rmag;
      pay2  <= udy1[UD_W-1:H] * rmag;
      pbx2  <= udx1[H-1:0] * rmag;
      pby2  <= udy1[H-1:0] * rmag;
    end
  end

  // stage 3: displacement
  logic [SUM_W-1:0]       sumx, sumy;
  logic                   hit3, axis3, nx3, ny3;
  logic [R:0]             re3;
  logic signed [P-1:0]    push3, tx3, ty3;
  logic signed [P:0]      gx3, gy3;
  logic [TL_W-1:0]        tl3;
  logic [P:0]             dispx3, dispy3;

  always_comb begin
    sumx = (SUM_W'(pax2) << H) + SUM_W'(pbx2);
    sumy = (SUM_W'(pay2) << H) + SUM_W'(pby2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit3   <= hit2;
      axis3  <= axis2;
      nx3    <= nx2;
      ny3    <= ny2;
      re3    <= re2;
      push3  <= push2;
      tx3    <= tx2;
      ty3    <= ty2;
      gx3    <= gx2;
      gy3    <= gy2;
      tl3    <= tp2[R+TL_W-1:R];
      dispx3 <= sumx[SUM_W-1:R+DT_W];
      dispy3 <= sumy[SUM_W-1:R+DT_W];
    end
  end

  // stage 4: contact and output register
  logic signed [P+1:0] cxs, cys, txe, tye, dxs, dys;
  logic signed [P-1:0] cxq, cyq;

  always_comb begin
    txe = {{2{tx3[P-1]}}, tx3};
    tye = {{2{ty3[P-1]}}, ty3};
    dxs = {1'b0, dispx3};
    dys = {1'b0, dispy3};
    cxs = nx3 ? txe - dxs : txe + dxs;
    cys = ny3 ? tye - dys : tye + dys;
    if ((cxs[P+1] != cxs[P]) || (cxs[P] != cxs[P-1])) begin
      cxq = {cxs[P+1], {(P-1){~cxs[P+1]}}};
    end else begin
      cxq = cxs[P-1:0];
    end
    if ((cys[P+1] != cys[P]) || (cys[P] != cys[P-1])) begin
      cyq = {cys[P+1], {(P-1){~cys[P+1]}}};
    end else begin
      cyq = cys[P-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= hit3;
      gap_x <= gx3;
      gap_y <= gy3;
      if (hit3) begin
        hit_axis    <= axis3;
        push_x      <= axis3 ? '0 : push3;
        push_y      <= axis3 ? push3 : '0;
        entry_ratio <= re3;
        time_left   <= tl3;
        contact_x   <= cxq;
        contact_y   <= cyq;
      end else begin
        hit_axis    <= 1'b0;
        push_x      <= '0;
        push_y      <= '0;
        entry_ratio <= ONE[R:0];
        time_left   <= '1;
        contact_x   <= '0;
        contact_y   <= '0;
      end
    end
  end

endmodule

// File: rtl/core/sbc_checker.sv
// sbc_checker: port-level checks for swept_box_collision, bound to the top.
// Uses sbc_pkg.
module sbc_checker import sbc_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int RATIO_FRAC_BITS = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              hit,
  input logic                              hit_axis,
  input logic signed [COORD_WIDTH-1:0]     push_x,
  input logic signed [COORD_WIDTH-1:0]     push_y,
  input logic [RATIO_FRAC_BITS:0]          entry_ratio,
  input logic [TL_W-1:0]                   time_left,
  input logic signed [COORD_WIDTH-1:0]     contact_x,
  input logic signed [COORD_WIDTH-1:0]     contact_y
);
  localparam logic [RATIO_FRAC_BITS:0] ONE = (RATIO_FRAC_BITS+1)'(1) << RATIO_FRAC_BITS;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_ratio) && $stable(contact_x))
    else $error("result changed while stalled");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> entry_ratio == ONE && time_left == '1 &&
                         contact_x == '0 && contact_y == '0)
    else $error("miss result fields wrong");

  a_miss_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> !hit_axis && push_x == '0 && push_y == '0)
    else $error("push on miss");

  a_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (hit_axis ? push_x == '0 : push_y == '0))
    else $error("push on the wrong axis");

  a_ratio: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> entry_ratio <= ONE)
    else $error("entry ratio above one on hit");

endmodule

bind swept_box_collision sbc_checker #(
  .COORD_WIDTH(COORD_WIDTH), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
) u_sbc_checker (.*);

// File: bench/swept_box_collision_tb.sv
// swept_box_collision_tb: self-checking bench for the swept box collision pipeline.
// Predicts every result in SystemVerilog and checks it field by field.
// Depends on sbc_pkg and swept_box_collision.
`timescale 1ns / 1ps

module swept_box_collision_tb;
  import sbc_pkg::*;

  localparam int CW = 24;
  localparam int RF = 16;
  localparam longint ONE_Q = longint'(1) << RF;
  localparam longint LIM_Q = ONE_Q * 4;
  localparam longint INF_Q = ONE_Q * 8;
  localparam int TAIL = RF + 30;

  typedef struct {
    logic signed [CW-1:0] tx, ty, tvx, tvy, ox, oy, ovx, ovy;
    logic [CW-3:0] tw, th, ow, oh;
  } pair_t;

  typedef struct {
    logic hit, axis;
    logic signed [CW-1:0] px, py, cx, cy;
    logic [RF:0] ratio;
    logic [TL_W-1:0] tleft;
    logic signed [CW:0] gx, gy;
  } hit_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [DT_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 0;
  pair_t drv = '{default: '0};
  hit_t got;

  logic [DT_W-1:0] frame_q = FT_RESET;
  hit_t pending_hits[$];
  int mismatches = 0;
  int rx_hold = 0;
  bit no_idle = 0;

  swept_box_collision DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .tgt_x(drv.tx), .tgt_y(drv.ty), .tgt_w(drv.tw), .tgt_h(drv.th),
    .tgt_vx(drv.tvx), .tgt_vy(drv.tvy),
    .oth_x(drv.ox), .oth_y(drv.oy), .oth_w(drv.ow), .oth_h(drv.oh),
    .oth_vx(drv.ovx), .oth_vy(drv.ovy),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(got.hit), .hit_axis(got.axis), .push_x(got.px), .push_y(got.py),
    .entry_ratio(got.ratio), .time_left(got.tleft),
    .contact_x(got.cx), .contact_y(got.cy), .gap_x(got.gx), .gap_y(got.gy)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint clamp_w(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // floor(n * 2^(16+RF) / d), clamped to +-4.0
  function automatic longint entry_frac(longint n, longint d);
    longint unsigned un, ud, q, r;
    bit neg;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    neg = (n < 0) != (d < 0);
    if (un != 0 && (un << PRE_SHIFT) >= ud) return neg ? -LIM_Q : LIM_Q;
    q = un / ud;
    r = un % ud;
    for (int i = 0; i < 16 + RF; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
    end
    if (neg) return -longint'(q) - (r != 0 ? 1 : 0);
    return longint'(q);
  endfunction

  function automatic longint push_of(longint gap, longint v);
    longint av;
    av = v < 0 ? -v : v;
    if (gap == 0) return -v;
    return gap < 0 ? av : -av;
  endfunction

  function automatic longint contact_of(longint pos, longint rv, longint dt, longint re);
    longint d, disp;
    longint unsigned ad;
    d = rv * dt;
    ad = d < 0 ? -d : d;
    disp = longint'((ad * longint'(re)) >> (RF + 16));
    return d < 0 ? pos - disp : pos + disp;
  endfunction

  function automatic hit_t predict_hit(pair_t p, logic [DT_W-1:0] ft);
    hit_t e;
    longint tx, ty, tvx, tvy, ox, oy, ovx, ovy, dt, rvx, rvy;
    longint xlo, xhi, ylo, yhi, dxe, dxx, dye, dyx, rxe, rxx, rye, ryx, re, rx;
    bit miss;
    tx = p.tx; ty = p.ty; tvx = p.tvx; tvy = p.tvy;
    ox = p.ox; oy = p.oy; ovx = p.ovx; ovy = p.ovy;
    dt = longint'(ft);
    rvx = tvx - ovx;
    rvy = tvy - ovy;
    xlo = (2 * (ox - tx) - (longint'(p.tw) + longint'(p.ow))) >>> 1;
    xhi = (2 * (ox - tx) + (longint'(p.tw) + longint'(p.ow))) >>> 1;
    ylo = (2 * (oy - ty) - (longint'(p.th) + longint'(p.oh))) >>> 1;
    yhi = (2 * (oy - ty) + (longint'(p.th) + longint'(p.oh))) >>> 1;
    dxe = rvx > 0 ? xlo : xhi;
    dxx = rvx > 0 ? xhi : xlo;
    dye = rvy > 0 ? ylo : yhi;
    dyx = rvy > 0 ? yhi : ylo;
    rxe = -INF_Q; rxx = INF_Q; rye = -INF_Q; ryx = INF_Q;
    if (tvx != 0 && rvx != 0 && dt != 0) begin
      rxe = entry_frac(dxe, rvx * dt);
      rxx = entry_frac(dxx, rvx * dt);
    end
    if (tvy != 0 && rvy != 0 && dt != 0) begin
      rye = entry_frac(dye, rvy * dt);
      ryx = entry_frac(dyx, rvy * dt);
    end
    re = rxe > rye ? rxe : rye;
    rx = rxx < ryx ? rxx : ryx;
    miss = re > rx || (rxe < 0 && rye < 0) || rxe > ONE_Q || rye > ONE_Q;
    e = '{default: '0};
    e.gx = clamp_w(dxe, CW + 1);
    e.gy = clamp_w(dye, CW + 1);
    if (miss) begin
      e.ratio = ONE_Q;
      e.tleft = '1;
      return e;
    end
    e.hit = 1;
    e.axis = !(rxe > rye);
    if (rxe > rye) e.px = clamp_w(push_of(dxe, tvx), CW);
    else e.py = clamp_w(push_of(dye, tvy), CW);
    e.ratio = re;
    e.tleft = (dt * (ONE_Q - re)) >> RF;
    e.cx = clamp_w(contact_of(tx, rvx, dt, re), CW);
    e.cy = clamp_w(contact_of(ty, rvy, dt, re), CW);
    return e;
  endfunction

  task automatic check_field(string name, longint want, longint seen);
    if (want != seen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    hit_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no item pending", $realtime);
      end else begin
        e = pending_hits.pop_front();
        check_field("hit", e.hit, got.hit);
        check_field("hit_axis", e.axis, got.axis);
        check_field("push_x", e.px, got.px);
        check_field("push_y", e.py, got.py);
        check_field("entry_ratio", e.ratio, got.ratio);
        check_field("time_left", e.tleft, got.tleft);
        check_field("contact_x", e.cx, got.cx);
        check_field("contact_y", e.cy, got.cy);
        check_field("gap_x", e.gx, got.gx);
        check_field("gap_y", e.gy, got.gy);
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pair(pair_t p);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 12);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    drv <= p;
    do @(posedge clk); while (!in_ready);
    pending_hits = {pending_hits, predict_hit(p, frame_q)};
  endtask

  task automatic drain;
    in_valid <= 0;
    wait (pending_hits.size() == 0);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_frame(logic [DT_W-1:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    frame_q = v;
  endtask

  function automatic int span_rand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic pair_t box_pair(int px, int py, int w, int vx, int vy,
                                     int qx, int qy, int qw, int qvx, int qvy);
    pair_t p;
    p.tx = px; p.ty = py; p.tw = w; p.th = w; p.tvx = vx; p.tvy = vy;
    p.ox = qx; p.oy = qy; p.ow = qw; p.oh = qw; p.ovx = qvx; p.ovy = qvy;
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int vmax, bx, by;
    longint lim;
    if ($urandom_range(0, 3) == 0) begin
      p.tx = $urandom; p.ty = $urandom; p.tvx = $urandom; p.tvy = $urandom;
      p.ox = $urandom; p.oy = $urandom; p.ovx = $urandom; p.ovy = $urandom;
      p.tw = $urandom; p.th = $urandom; p.ow = $urandom; p.oh = $urandom;
      return p;
    end
    // nearby boxes with velocities that cover the gap within a frame
    lim = 64'sd2621440000 / longint'(frame_q);
    if (lim > 8000000) lim = 8000000;
    vmax = int'(lim);
    bx = span_rand(1 << 20);
    by = span_rand(1 << 20);
    p.tx = bx; p.ty = by;
    p.ox = bx + span_rand(20000); p.oy = by + span_rand(20000);
    p.tw = $urandom_range(0, 8000); p.th = $urandom_range(0, 8000);
    p.ow = $urandom_range(0, 8000); p.oh = $urandom_range(0, 8000);
    p.tvx = span_rand(vmax); p.tvy = span_rand(vmax);
    p.ovx = span_rand(vmax / 4); p.ovy = span_rand(vmax / 4);
    case ($urandom_range(0, 7))
      0: p.tvx = 0;
      1: p.tvy = 0;
      2: p.ovx = p.tvx;
      3: p.ovy = p.tvy;
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_directed;
    int mx, mn, sz;
    mx = (1 << 23) - 1;
    mn = -(1 << 23);
    sz = (1 << 22) - 1;
    send_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(box_pair(0, 0, 256, 200000, 0, 2560, 0, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, 0, 200000, 0, 2560, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, -200000, 0, -2560, 0, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, 150000, 0, 256, 0, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, -150000, 0, -256, 0, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, 0, 150000, 0, 256, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, 5000, 0, 2560, 0, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, -200000, 0, 2560, 0, 256, 0, 0));
    send_pair(box_pair(0, 0, 256, 100000, 0, 2560, 0, 256, 100000, 0));
    send_pair(box_pair(0, 0, 256, 0, 0, 2560, 0, 256, -200000, 0));
    send_pair(box_pair(0, 0, 512, 200000, 200000, 2000, 2000, 512, 0, 0));
    send_pair(box_pair(0, 0, 512, 200000, 200000, 2000, 6000, 512, 0, 0));
    send_pair(box_pair(0, 0, 256, 100, 0, 128, 0, 256, 0, 0));
    send_pair(box_pair(mx, mx, sz, mx, mx, mn, mn, sz, mn, mn));
    send_pair(box_pair(mn, mn, sz, mn, mn, mx, mx, sz, mx, mx));
    send_pair(box_pair(mn, mn, 0, mx, mx, mx, mx, 0, mn, mn));
    send_pair(box_pair(mx, 0, sz, mn, 0, mn, 0, sz, mx, 0));
    send_pair(box_pair(0, 0, sz, mx, mx, 0, 0, sz, mn, mn));
    send_pair(box_pair(-1, -1, 1, -1, -1, 1, 1, 1, 1, 1));
    send_pair(box_pair(0, 0, 256, 8000000, 0, 500000, 0, 256, -8000000, 0));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i % 100) >= 80;
      send_pair(random_pair());
    end
    no_idle = 0;
    drain();
  endtask

  task automatic test_backpressure;
    rx_hold = 300;
    no_idle = 1;
    for (int i = 0; i < 60; i++) send_pair(random_pair());
    no_idle = 0;
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    write_frame(16'd1);
    test_directed();
    test_random(100);
    write_frame(16'hFFFF);
    test_directed();
    test_random(150);
    write_frame($urandom_range(1, 65535));
    test_random(150);
    write_frame(FT_RESET);
    test_random(50);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
